/* hdl/cwsg_pkg.sv */
// Shared types and constants for the congestion window send gate.
// No dependencies.
package cwsg_pkg;

	localparam int unsigned CFG_BITS = 16;

	typedef logic [1:0] func_t;
	localparam func_t FN_SEND   = 2'd0;
	localparam func_t FN_EXPIRE = 2'd1;
	localparam func_t FN_OPEN   = 2'd2;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_MIN_WINDOW     = 2'd0;
	localparam cfg_index_t CFG_INIT_WINDOW    = 2'd1;
	localparam cfg_index_t CFG_INIT_THRESHOLD = 2'd2;

	localparam logic [CFG_BITS-1:0] RST_MIN_WINDOW     = 16'd1;
	localparam logic [CFG_BITS-1:0] RST_INIT_WINDOW    = 16'd1;
	localparam logic [CFG_BITS-1:0] RST_INIT_THRESHOLD = 16'd64;

	localparam logic [31:0] LOSS_LIMIT = 32'd2;

	typedef enum logic [1:0] {
		TS_NONE = 2'd0,
		TS_RUN  = 2'd1,
		TS_DONE = 2'd2
	} timer_t;

	typedef struct packed {
		func_t       func;
		logic [3:0]  conn_id;
		logic [31:0] seq_next;
		logic [31:0] seq_unack;
		logic        data_phase;
	} in_t;

	typedef struct packed {
		logic permit;
		logic timer_start;
		logic mode;
		logic congestion_seen;
	} out_t;

endpackage

/* hdl/cwsg_conn_update.sv */
// Per-connection decision and next-state logic for one request.
// Depends on cwsg_pkg.
module cwsg_conn_update import cwsg_pkg::*; #(
	parameter int unsigned WINDOW_BITS = 16
) (
	input  in_t                    item,
	input  logic                   in_range,
	input  logic [WINDOW_BITS-1:0] window,
	input  logic [WINDOW_BITS-1:0] threshold,
	input  logic [WINDOW_BITS-1:0] send_count,
	input  timer_t                 timer,
	input  logic [CFG_BITS-1:0]    min_window,
	input  logic [CFG_BITS-1:0]    initial_window,
	input  logic [CFG_BITS-1:0]    initial_threshold,
	output logic [WINDOW_BITS-1:0] window_nxt,
	output logic [WINDOW_BITS-1:0] threshold_nxt,
	output logic [WINDOW_BITS-1:0] send_count_nxt,
	output timer_t                 timer_nxt,
	output out_t                   result
);

	logic [47:0]            min_ext, iwin_ext, ithr_ext;
	logic [WINDOW_BITS-1:0] min_w, iwin_w, ithr_w;
	logic                   mode;
	logic                   loss;
	logic [31:0]            in_flight;
	logic [WINDOW_BITS-1:0] incr;
	logic [WINDOW_BITS:0]   grow_sum;
	logic [WINDOW_BITS-1:0] grown;

	assign min_ext  = {32'd0, min_window};
	assign iwin_ext = {32'd0, initial_window};
	assign ithr_ext = {32'd0, initial_threshold};
	assign min_w    = min_ext[WINDOW_BITS-1:0];
	assign iwin_w   = iwin_ext[WINDOW_BITS-1:0];
	assign ithr_w   = ithr_ext[WINDOW_BITS-1:0];

	assign mode      = !(window < threshold);
	assign in_flight = item.seq_next - item.seq_unack;
	assign loss      = in_flight > LOSS_LIMIT;

	assign incr     = mode ? {{(WINDOW_BITS-1){1'b0}}, 1'b1} : send_count;
	assign grow_sum = {1'b0, window} + {1'b0, incr};
	assign grown    = grow_sum[WINDOW_BITS] ? {WINDOW_BITS{1'b1}} : grow_sum[WINDOW_BITS-1:0];

	always_comb begin
		window_nxt     = window;
		threshold_nxt  = threshold;
		send_count_nxt = send_count;
		timer_nxt      = timer;
		result         = '0;
		if (in_range) begin
			result.mode = mode;
			case (item.func)
				FN_EXPIRE: begin
					if (timer == TS_RUN)
						timer_nxt = TS_DONE;
				end
				FN_OPEN: begin
					window_nxt     = iwin_w;
					threshold_nxt  = ithr_w;
					send_count_nxt = '0;
					timer_nxt      = TS_NONE;
				end
				FN_SEND: begin
					if (!item.data_phase) begin
						result.permit = 1'b1;
					end else if (timer == TS_DONE) begin
						result.timer_start = 1'b1;
						timer_nxt          = TS_RUN;
						if (loss) begin
							result.congestion_seen = 1'b1;
							window_nxt             = min_w;
							send_count_nxt         = '0;
							if (threshold > {{(WINDOW_BITS-1){1'b0}}, 1'b1})
								threshold_nxt = mode ? (window >> 1) : (threshold >> 1);
						end else begin
							result.permit  = 1'b1;
							window_nxt     = grown;
							send_count_nxt = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
						end
					end else begin
						// fresh timer starts, then judged as running
						if (timer != TS_RUN) begin
							result.timer_start = 1'b1;
							timer_nxt          = TS_RUN;
						end
						if (send_count < window) begin
							send_count_nxt = send_count + {{(WINDOW_BITS-1){1'b0}}, 1'b1};
							result.permit  = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* hdl/congestion_window_send_gate_top.sv */
// Congestion window send gate, top level: input register, per-connection state,
// result register and configuration registers. Depends on cwsg_pkg, cwsg_conn_update.
// Result path: input register, then the update logic, then the result register and its strobe.
// Throughput: one request per cycle when not busy; state is read and written in the same stage.
// Reset: all connections return to window 1, threshold 64, count 0, no timer;
// busy is high during reset and until the first clock edge after its release. Results cannot be stalled.
module congestion_window_send_gate_top import cwsg_pkg::*; #(
	parameter int unsigned CONNECTIONS = 16,
	parameter int unsigned WINDOW_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  in_t                 item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_index_t          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output logic                result_valid,
	output out_t                result
);

	localparam int unsigned IDX_BITS = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam logic [31:0] RST_WINDOW    = 32'd1;
	localparam logic [31:0] RST_THRESHOLD = 32'd64;

	logic                   ready_q;
	logic [CFG_BITS-1:0]    min_window_q, init_window_q, init_threshold_q;
	logic                   valid_s1;
	in_t                    item_s1;

	logic [WINDOW_BITS-1:0] window_q     [CONNECTIONS];
	logic [WINDOW_BITS-1:0] threshold_q  [CONNECTIONS];
	logic [WINDOW_BITS-1:0] send_count_q [CONNECTIONS];
	timer_t                 timer_q      [CONNECTIONS];

	logic [8:0]             id_ext;
	logic                   in_range;
	logic [IDX_BITS-1:0]    idx;
	logic [WINDOW_BITS-1:0] window_nxt, threshold_nxt, send_count_nxt;
	logic [WINDOW_BITS-1:0] window_rd, threshold_rd, send_count_rd;
	timer_t                 timer_rd, timer_nxt;
	out_t                   result_nxt;
	logic                   accept;
	out_t                   result_q;
	logic                   result_valid_q;

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_window_q     <= RST_MIN_WINDOW;
			init_window_q    <= RST_INIT_WINDOW;
			init_threshold_q <= RST_INIT_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_WINDOW:     min_window_q     <= cfg_data;
				CFG_INIT_WINDOW:    init_window_q    <= cfg_data;
				CFG_INIT_THRESHOLD: init_threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	assign id_ext   = {5'd0, item_s1.conn_id};
	assign in_range = id_ext < 9'(CONNECTIONS);
	assign idx      = id_ext[IDX_BITS-1:0];

	assign window_rd     = in_range ? window_q[idx]     : '0;
	assign threshold_rd  = in_range ? threshold_q[idx]  : '0;
	assign send_count_rd = in_range ? send_count_q[idx] : '0;
	assign timer_rd      = in_range ? timer_q[idx]      : TS_NONE;

	cwsg_conn_update #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_update (
		.item              (item_s1),
		.in_range          (in_range),
		.window            (window_rd),
		.threshold         (threshold_rd),
		.send_count        (send_count_rd),
		.timer             (timer_rd),
		.min_window        (min_window_q),
		.initial_window    (init_window_q),
		.initial_threshold (init_threshold_q),
		.window_nxt        (window_nxt),
		.threshold_nxt     (threshold_nxt),
		.send_count_nxt    (send_count_nxt),
		.timer_nxt         (timer_nxt),
		.result            (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONNECTIONS; i++) begin
				window_q[i]     <= RST_WINDOW[WINDOW_BITS-1:0];
				threshold_q[i]  <= RST_THRESHOLD[WINDOW_BITS-1:0];
				send_count_q[i] <= '0;
				timer_q[i]      <= TS_NONE;
			end
		end else if (valid_s1 && in_range) begin
			window_q[idx]     <= window_nxt;
			threshold_q[idx]  <= threshold_nxt;
			send_count_q[idx] <= send_count_nxt;
			timer_q[idx]      <= timer_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			result_q <= result_nxt;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// every strobe answers exactly one accepted transaction, passed through the input and result registers
	a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 2))
		else $error("result strobe without accepted transaction");

	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid)
		else $error("accepted transaction lost between stages");

	a_loss_denies: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.congestion_seen |-> !result.permit && result.timer_start)
		else $error("congestion reported with permit or without timer restart");

endmodule
